// ===== rtl/lpic_pkg.sv =====
// Package for the LIN protected id and checksum block.
// Request and result codes, the result record and the id parity function.
// No dependencies.
package lpic_pkg;

    localparam int MAX_DATA_DEFAULT = 8;

    // request codes
    localparam logic [1:0] REQ_ID       = 2'd0;
    localparam logic [1:0] REQ_DATA     = 2'd1;
    localparam logic [1:0] REQ_CHECK    = 2'd2;
    localparam logic [1:0] REQ_GENERATE = 2'd3;

    // result codes
    localparam logic [1:0] KIND_PID     = 2'd0;
    localparam logic [1:0] KIND_VERDICT = 2'd1;
    localparam logic [1:0] KIND_GEN     = 2'd2;

    localparam logic [7:0] ID_MASK = 8'h3F;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] out_byte;
        logic       id_ok;
        logic       sum_ok;
        logic       too_long;
    } result_t;

    // P0 = id0^id1^id2^id4 in bit 6, P1 = ~(id1^id3^id4^id5) in bit 7
    function automatic logic [7:0] add_parity(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // LIN carry-add: a carry out of bit 7 wraps into bit 0
    function automatic logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

endpackage

// ===== rtl/lpic_calc.sv =====
// Frame state and per-transaction result logic of the LIN id/checksum block.
// Depends on lpic_pkg.
module lpic_calc #(
    parameter int MAX_DATA = lpic_pkg::MAX_DATA_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic [1:0]       req_type,
    input  logic [7:0]       value,
    input  logic             enhanced,
    output lpic_pkg::result_t result
);

    localparam int CNT_W = $clog2(MAX_DATA + 1);

    logic [7:0]       running_sum_reg, running_sum_next;
    logic [7:0]       frame_id_reg, frame_id_next;
    logic             frame_id_good_reg, frame_id_good_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             overflowed_reg, overflowed_next;

    logic [7:0] computed;
    logic [7:0] parity_id;
    logic [7:0] pid;
    logic       pid_good;

    assign computed  = ~running_sum_reg;
    assign parity_id = lpic_pkg::add_parity(value[5:0]);
    // values above 63 are received protected ids: pass through and check
    assign pid       = (value[7:6] == 2'b00) ? parity_id : value;
    assign pid_good  = (value[7:6] == 2'b00) ? 1'b1 : (parity_id == value);

    always_comb begin
        running_sum_next   = running_sum_reg;
        frame_id_next      = frame_id_reg;
        frame_id_good_next = frame_id_good_reg;
        byte_count_next    = byte_count_reg;
        overflowed_next    = overflowed_reg;
        result.result_kind = lpic_pkg::KIND_GEN;
        result.out_byte    = computed;
        result.id_ok       = frame_id_good_reg;
        result.sum_ok      = 1'b0;
        result.too_long    = overflowed_reg;
        unique case (req_type)
            lpic_pkg::REQ_ID: begin
                frame_id_next      = pid;
                frame_id_good_next = pid_good;
                running_sum_next   = enhanced ? pid : 8'd0;
                byte_count_next    = '0;
                overflowed_next    = 1'b0;
                result.result_kind = lpic_pkg::KIND_PID;
                result.out_byte    = pid;
                result.id_ok       = pid_good;
                result.too_long    = 1'b0;
            end
            lpic_pkg::REQ_DATA: begin
                if (byte_count_reg < CNT_W'(MAX_DATA)) begin
                    running_sum_next = lpic_pkg::carry_add(running_sum_reg, value);
                    byte_count_next  = byte_count_reg + CNT_W'(1);
                end else begin
                    overflowed_next = 1'b1;
                end
            end
            lpic_pkg::REQ_CHECK: begin
                result.result_kind = lpic_pkg::KIND_VERDICT;
                result.sum_ok      = (value == computed);
            end
            lpic_pkg::REQ_GENERATE: begin
                result.result_kind = lpic_pkg::KIND_GEN;
            end
            default: begin
                result.result_kind = lpic_pkg::KIND_GEN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg   <= 8'd0;
            frame_id_reg      <= 8'd0;
            frame_id_good_reg <= 1'b0;
            byte_count_reg    <= '0;
            overflowed_reg    <= 1'b0;
        end else if (advance) begin
            running_sum_reg   <= running_sum_next;
            frame_id_reg      <= frame_id_next;
            frame_id_good_reg <= frame_id_good_next;
            byte_count_reg    <= byte_count_next;
            overflowed_reg    <= overflowed_next;
        end
    end

endmodule

// ===== rtl/lin_protected_id_and_checksum.sv =====
// Top level of the LIN protected id and checksum block.
// Input register, lpic_calc and result register. Depends on lpic_pkg, lpic_calc.
//
// Usage: the s_ channel carries one LIN frame item per transaction:
// an identifier (starts a frame, s_enhanced selects enhanced checksum),
// data bytes, a received checksum byte to verify, or a generate request.
// Identifier, verify and generate transactions each give one m_ result;
// data bytes give none. Bytes beyond MAX_DATA are dropped and flagged as
// m_too_long on later results of the frame.
// Timing: transactions wait in the input register, and results pass through
// the result register, which drives m_valid. Throughput: one transaction per
// cycle unless a result waits on a full result register; the checksum
// carry-add and the parity logic sit in one stage between the two registers.
// Stall: while m_ready is low the result holds; the input register still
// takes one more transaction, and data bytes keep flowing since they need
// no result slot. s_ready drops only when a result-bearing transaction waits
// on a full result register.
// Reset (aresetn low, synchronous): both registers empty, sum, id, count
// and overflow flag cleared; no clearing sweep is needed.
module lin_protected_id_and_checksum #(
    parameter int MAX_DATA = lpic_pkg::MAX_DATA_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_value,
    input  logic       s_enhanced,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_result_kind,
    output logic [7:0] m_out_byte,
    output logic       m_id_ok,
    output logic       m_sum_ok,
    output logic       m_too_long
);

    logic       in_valid_reg, in_valid_next;
    logic [1:0] in_type_reg;
    logic [7:0] in_value_reg;
    logic       in_enh_reg;
    logic       out_valid_reg, out_valid_next;
    lpic_pkg::result_t out_reg;
    lpic_pkg::result_t calc_result;

    logic needs_out;
    logic out_free;
    logic advance;
    logic in_take;

    assign needs_out = (in_type_reg != lpic_pkg::REQ_DATA);
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && (!needs_out || out_free);
    assign s_ready   = !in_valid_reg || advance;
    assign in_take   = s_valid && s_ready;

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = (advance && needs_out) || (out_valid_reg && !m_ready);

    lpic_calc #(
        .MAX_DATA(MAX_DATA)
    ) u_calc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .req_type (in_type_reg),
        .value    (in_value_reg),
        .enhanced (in_enh_reg),
        .result   (calc_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_type_reg  <= s_req_type;
            in_value_reg <= s_value;
            in_enh_reg   <= s_enhanced;
        end
        if (advance && needs_out) begin
            out_reg <= calc_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_reg.result_kind;
    assign m_out_byte    = out_reg.out_byte;
    assign m_id_ok       = out_reg.id_ok;
    assign m_sum_ok      = out_reg.sum_ok;
    assign m_too_long    = out_reg.too_long;

endmodule

// ===== rtl/lpic_checker.sv =====
// Port-level checker for lin_protected_id_and_checksum, bound to the top level.
// Depends on lpic_pkg.
module lpic_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_result_kind,
    input logic [7:0] m_out_byte,
    input logic       m_id_ok,
    input logic       m_sum_ok,
    input logic       m_too_long
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_result_kind) && $stable(m_sum_ok))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_result_kind == lpic_pkg::KIND_PID
            || m_result_kind == lpic_pkg::KIND_VERDICT
            || m_result_kind == lpic_pkg::KIND_GEN)
        else $error("illegal result kind");

    // a protected id result carries its own parity verdict
    a_pid_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == lpic_pkg::KIND_PID |->
            m_id_ok == (lpic_pkg::add_parity(m_out_byte[5:0]) == m_out_byte))
        else $error("protected id verdict mismatch");

    a_pid_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == lpic_pkg::KIND_PID |-> !m_sum_ok && !m_too_long)
        else $error("flags set on protected id result");

    a_gen_no_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == lpic_pkg::KIND_GEN |-> !m_sum_ok)
        else $error("sum_ok set on generated checksum");

endmodule

bind lin_protected_id_and_checksum lpic_checker u_lpic_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_kind (m_result_kind),
    .m_out_byte    (m_out_byte),
    .m_id_ok       (m_id_ok),
    .m_sum_ok      (m_sum_ok),
    .m_too_long    (m_too_long)
);

// ===== tb/sv/lin_protected_id_and_checksum_tb.sv =====
// Testbench for lin_protected_id_and_checksum: protected id parity and LIN carry-add checksum.
// A scoreboard class predicts every transaction; plain tasks drive frames with random idling.
// Depends on lpic_pkg and the lin_protected_id_and_checksum RTL.
module lin_protected_id_and_checksum_tb;

    localparam int MAX_BYTES = lpic_pkg::MAX_DATA_DEFAULT;
    localparam int RUN_LIMIT = 4_000_000;

    class frame_scoreboard;
        lpic_pkg::result_t replies_due[$];
        logic [7:0] sum_acc;
        logic [7:0] pid_reg;
        logic       pid_good;
        int         data_cnt;
        logic       overflow_seen;
        int         errors;

        function new();
            sum_acc = 8'h00;
            pid_reg = 8'h00;
            pid_good = 1'b0;
            data_cnt = 0;
            overflow_seen = 1'b0;
            errors = 0;
        endfunction

        // P0 over id bits 0,1,2,4; P1 inverted over bits 1,3,4,5
        function logic [7:0] protect_id(logic [5:0] id);
            logic [7:0] pid;
            pid[5:0] = id;
            pid[6] = ^(id & 6'b010111);
            pid[7] = ~^(id & 6'b111010);
            return pid;
        endfunction

        // end-around carry
        function logic [7:0] sum_add(logic [7:0] a, logic [7:0] b);
            int s;
            s = a + b;
            if (s > 255)
                s = s - 255;
            return 8'(s);
        endfunction

        function logic [7:0] inverted_sum();
            return ~sum_acc;
        endfunction

        function void note_item(logic [1:0] req, logic [7:0] val, logic enh);
            lpic_pkg::result_t r;
            logic [7:0]        inv;
            inv = ~sum_acc;
            r = '0;
            case (req)
                lpic_pkg::REQ_ID: begin
                    if (val <= lpic_pkg::ID_MASK) begin
                        pid_reg = protect_id(val[5:0]);
                        pid_good = 1'b1;
                    end else begin
                        pid_reg = val;
                        pid_good = (protect_id(val[5:0]) == val);
                    end
                    sum_acc = enh ? pid_reg : 8'h00;
                    data_cnt = 0;
                    overflow_seen = 1'b0;
                    r.result_kind = lpic_pkg::KIND_PID;
                    r.out_byte = pid_reg;
                    r.id_ok = pid_good;
                    replies_due.push_back(r);
                end
                lpic_pkg::REQ_DATA: begin
                    if (data_cnt < MAX_BYTES) begin
                        sum_acc = sum_add(sum_acc, val);
                        data_cnt++;
                    end else begin
                        overflow_seen = 1'b1;
                    end
                end
                default: begin
                    r.result_kind = (req == lpic_pkg::REQ_CHECK) ? lpic_pkg::KIND_VERDICT
                                                                 : lpic_pkg::KIND_GEN;
                    r.out_byte = inv;
                    r.id_ok = pid_good;
                    r.sum_ok = (req == lpic_pkg::REQ_CHECK) && (val == inv);
                    r.too_long = overflow_seen;
                    replies_due.push_back(r);
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_reply(lpic_pkg::result_t got);
            lpic_pkg::result_t want;
            if (replies_due.size() == 0) begin
                report($sformatf("result kind %0d byte %02h with nothing expected",
                                 got.result_kind, got.out_byte));
            end else begin
                want = replies_due.pop_front();
                if (got.result_kind !== want.result_kind)
                    report($sformatf("result_kind %0d, want %0d",
                                     got.result_kind, want.result_kind));
                if (got.out_byte !== want.out_byte)
                    report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
                if (got.id_ok !== want.id_ok)
                    report($sformatf("id_ok %b, want %b", got.id_ok, want.id_ok));
                if (got.sum_ok !== want.sum_ok)
                    report($sformatf("sum_ok %b, want %b", got.sum_ok, want.sum_ok));
                if (got.too_long !== want.too_long)
                    report($sformatf("too_long %b, want %b", got.too_long, want.too_long));
            end
        endtask
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_req_type = lpic_pkg::REQ_ID;
    logic [7:0] s_value = 8'h00;
    logic       s_enhanced = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_result_kind;
    logic [7:0] m_out_byte;
    logic       m_id_ok;
    logic       m_sum_ok;
    logic       m_too_long;

    frame_scoreboard book = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int rx_hold = 0;
    int items_sent = 0;

    always #4 aclk = ~aclk;

    lin_protected_id_and_checksum #(
        .MAX_DATA(MAX_BYTES)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_value(s_value),
        .s_enhanced(s_enhanced),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result_kind(m_result_kind),
        .m_out_byte(m_out_byte),
        .m_id_ok(m_id_ok),
        .m_sum_ok(m_sum_ok),
        .m_too_long(m_too_long)
    );

    task automatic send_item(logic [1:0] req, logic [7:0] val, logic enh);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_value <= val;
        s_enhanced <= enh;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        book.note_item(req, val, enh);
        items_sent++;
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (book.replies_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_frame();
        logic [7:0] id;
        int         n;
        int         pick;
        pick = $urandom_range(9);
        if (pick < 6)
            id = 8'($urandom_range(63));
        else if (pick < 8)
            id = book.protect_id(6'($urandom_range(63)));
        else
            id = 8'($urandom_range(255));
        send_item(lpic_pkg::REQ_ID, id, 1'($urandom_range(1)));
        if ($urandom_range(9) == 0)
            n = $urandom_range(MAX_BYTES + 4, MAX_BYTES + 1);
        else
            n = $urandom_range(MAX_BYTES);
        repeat (n)
            send_item(lpic_pkg::REQ_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
        case ($urandom_range(5))
            0, 1, 2: begin
                send_item(lpic_pkg::REQ_CHECK, book.inverted_sum(), 1'($urandom_range(1)));
            end
            3: begin
                send_item(lpic_pkg::REQ_CHECK, 8'($urandom_range(255)),
                          1'($urandom_range(1)));
            end
            4: begin
                send_item(lpic_pkg::REQ_GENERATE, 8'($urandom_range(255)),
                          1'($urandom_range(1)));
            end
            default: begin
                send_item(lpic_pkg::REQ_GENERATE, 8'($urandom_range(255)),
                          1'($urandom_range(1)));
                send_item(lpic_pkg::REQ_CHECK, book.inverted_sum(), 1'($urandom_range(1)));
            end
        endcase
    endtask

    // mostly whole frames, some stray transactions of any type
    task automatic run_traffic(int upto);
        while (items_sent < upto) begin
            if ($urandom_range(9) == 0)
                send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
            else
                send_frame();
        end
    endtask

    // result side: check, then pick m_ready for the next cycle
    initial begin
        lpic_pkg::result_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = {m_result_kind, m_out_byte, m_id_ok, m_sum_ok, m_too_long};
                book.check_reply(got);
            end
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #RUN_LIMIT;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int i;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // before any identifier: reset state, id not good
        send_item(lpic_pkg::REQ_GENERATE, 8'h00, 1'b0);
        send_item(lpic_pkg::REQ_CHECK, 8'hFF, 1'b1);
        // classic frame, two 0xFF bytes exercise the end-around carry
        send_item(lpic_pkg::REQ_ID, 8'h00, 1'b0);
        send_item(lpic_pkg::REQ_DATA, 8'hFF, 1'b0);
        send_item(lpic_pkg::REQ_DATA, 8'hFF, 1'b1);
        send_item(lpic_pkg::REQ_GENERATE, 8'hFF, 1'b0);
        send_item(lpic_pkg::REQ_CHECK, 8'h00, 1'b0);
        // enhanced frame seeded with the protected id
        send_item(lpic_pkg::REQ_ID, 8'h3F, 1'b1);
        send_item(lpic_pkg::REQ_DATA, 8'h80, 1'b0);
        send_item(lpic_pkg::REQ_DATA, 8'h80, 1'b0);
        send_item(lpic_pkg::REQ_CHECK, book.inverted_sum(), 1'b0);
        // received protected id with good parity, then too many data bytes
        send_item(lpic_pkg::REQ_ID, 8'hC1, 1'b1);
        for (i = 0; i < MAX_BYTES + 1; i++)
            send_item(lpic_pkg::REQ_DATA, 8'(i * 8'h25), 1'b0);
        send_item(lpic_pkg::REQ_CHECK, book.inverted_sum(), 1'b0);
        send_item(lpic_pkg::REQ_GENERATE, 8'h55, 1'b1);
        // bad parity on a received protected id
        send_item(lpic_pkg::REQ_ID, 8'hFF, 1'b0);
        send_item(lpic_pkg::REQ_ID, 8'h40, 1'b1);
        send_item(lpic_pkg::REQ_GENERATE, 8'hAA, 1'b0);
        settle();

        send_idle_pct = 15;
        recv_idle_pct = 82;
        run_traffic(700);
        settle();

        send_idle_pct = 82;
        recv_idle_pct = 15;
        run_traffic(1400);
        settle();

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_hold = 200;
        run_traffic(1460);
        settle();

        run_traffic(2100);
        settle();

        repeat (8) @(posedge aclk);
        if (book.errors == 0 && book.replies_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
